### hw/rtl/pdsum_pkg.sv
package pdsum_pkg;

  localparam int NUMBER_IN_W = 16;
  localparam int SUM_W       = 18;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/pdsum_if.sv
interface pdsum_in_if;
  logic                               valid;
  logic                               ready;
  logic [pdsum_pkg::NUMBER_IN_W-1:0]  number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

interface pdsum_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdsum_pkg::SUM_W-1:0]   divisor_sum;

  modport source (output valid, output divisor_sum, input ready);
  modport sink   (input valid, input divisor_sum, output ready);
endinterface

### hw/rtl/proper_divisor_sum_unit.sv
// Sum of the proper divisors of the low NUMBER_BITS bits of number_in (0 for 0 and 1), by trial
// division with one shared restoring divider of min(NUMBER_BITS, 16) bits W. Trial divisors
// t = 2, 3, ... run until n / t < t, each trial as one full division in the divider. With the
// output free, the result register is loaded in the same cycle as the block goes back to idle,
// so the next number can be taken as soon as the result shows; numbers below 2 skip the divider.
// The block takes one number at a time: in_i.ready is high only while no number is in work.
// The result sits in an output register, so the next number may be taken while a result still
// waits. Sums above 2^18 - 1 saturate.
module proper_divisor_sum_unit #(
  parameter int NUMBER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdsum_in_if.sink    in_i,
  pdsum_out_if.source out_o
);

  localparam int NW    = (NUMBER_BITS < pdsum_pkg::NUMBER_IN_W) ? NUMBER_BITS
                                                                 : pdsum_pkg::NUMBER_IN_W;
  localparam int SW    = pdsum_pkg::SUM_W;
  localparam int ACC_W = SW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [NW-1:0]        n_q, t_q, n_in;
  logic [NW-1:0]        quo, rem, div_dividend, div_divisor;
  logic [SW-1:0]        sum_q, sum_sat, out_data_q;
  logic                 out_valid_q, out_free;
  logic                 in_acc, trial_ok, div_start;
  logic [NW:0]          addend;
  logic [ACC_W-1:0]     sum_ext;
  pdsum_pkg::div_stat_t div_stat;

  assign n_in        = in_i.number_in[NW-1:0];
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  // n / t >= t is the same as t * t <= n
  assign trial_ok     = (state_q == ST_DIV) && div_stat.done && (quo >= t_q);
  assign div_start    = (in_acc && (n_in >= NW'(2))) || trial_ok;
  assign div_dividend = (state_q == ST_IDLE) ? n_in : n_q;
  assign div_divisor  = (state_q == ST_IDLE) ? NW'(2) : t_q + NW'(1);

  pdsum_div #(
    .W (NW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (quo),
    .remainder_o (rem),
    .stat_o      (div_stat)
  );

  // root of a perfect square counts once
  always_comb begin
    addend = '0;
    if (rem == '0) begin
      addend = {1'b0, t_q} + ((quo == t_q) ? (NW + 1)'(0) : {1'b0, quo});
    end
  end

  assign sum_ext = ACC_W'(sum_q) + ACC_W'(addend);
  assign sum_sat = (sum_ext > ACC_W'(pdsum_pkg::SUM_MAX)) ? pdsum_pkg::SUM_MAX
                                                          : sum_ext[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q <= n_in;
            t_q <= NW'(2);
            if (n_in >= NW'(2)) begin
              sum_q   <= SW'(1);
              state_q <= ST_DIV;
            end else begin
              sum_q   <= '0;
              state_q <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (quo >= t_q) begin
              sum_q <= sum_sat;
              t_q   <= t_q + NW'(1);
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_q <= sum_q;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.divisor_sum = out_data_q;

endmodule

### hw/rtl/pdsum_div.sv
module pdsum_div #(
  parameter int W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [W-1:0]         dividend_i,
  input  logic [W-1:0]         divisor_i,
  output logic [W-1:0]         quotient_o,
  output logic [W-1:0]         remainder_o,
  output pdsum_pkg::div_stat_t stat_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q, quo_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [W:0]       trial, diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
        quo_q <= {quo_q[W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

### hw/rtl/pdsum_chk.sv
module pdsum_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [pdsum_pkg::SUM_W-1:0]   divisor_sum_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(divisor_sum_i))
    else $error("stalled result changed or dropped");

  // one number in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready while a number is in work");

  // no result shows up the cycle right after an accepted transaction
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

  // a new result comes with the block going back to idle
  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result without return to idle");

endmodule

bind proper_divisor_sum_unit pdsum_chk u_pdsum_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .divisor_sum_i (out_o.divisor_sum)
);

### sim/proper_divisor_sum_unit_test.sv
`timescale 1ns / 1ps

module proper_divisor_sum_unit_test;

  localparam int NUMBER_BITS = 16;
  localparam int MAX_IDLE    = 18;
  localparam int NUMBER_IN_W = pdsum_pkg::NUMBER_IN_W;
  localparam int SUM_W       = pdsum_pkg::SUM_W;

  typedef struct {
    logic [NUMBER_IN_W-1:0] number;
    logic [SUM_W-1:0]       sum;
  } sum_expect_t;

  logic clk;
  logic rst_n;

  pdsum_in_if  in_ch ();
  pdsum_out_if out_ch ();

  sum_expect_t pending_sums[$];
  int          error_count;
  bit          send_idle_on;
  bit          recv_idle_on;

  proper_divisor_sum_unit #(
    .NUMBER_BITS(NUMBER_BITS)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    // slowest correct run is well under 10 ms
    #40_000_000;
    $display("proper_divisor_sum_unit test failed");
    $finish;
  end

  function automatic logic [SUM_W-1:0] aliquot_sum(logic [NUMBER_IN_W-1:0] number);
    longint unsigned n;
    longint unsigned total;
    longint unsigned t;
    longint unsigned q;
    n = longint'(number) & ((64'd1 << NUMBER_BITS) - 1);
    if (n < 2) return '0;
    total = 1;
    for (t = 2; t * t <= n; t++) begin
      if (n % t == 0) begin
        q = n / t;
        total += t;
        // a square root counts once
        if (q != t) total += q;
      end
    end
    if (total > longint'(pdsum_pkg::SUM_MAX)) total = longint'(pdsum_pkg::SUM_MAX);
    return total[SUM_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_number(input logic [NUMBER_IN_W-1:0] number);
    int gap;
    sum_expect_t item;
    gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.number_in <= number;
    do @(posedge clk); while (!in_ch.ready);
    item.number = number;
    item.sum    = aliquot_sum(number);
    pending_sums.push_back(item);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // result checker, with random stalls on the output side
  initial begin
    int stall;
    sum_expect_t item;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("result %0d with no transaction pending",
                                  out_ch.divisor_sum));
      end else begin
        item = pending_sums.pop_front();
        if (out_ch.divisor_sum !== item.sum)
          report_mismatch($sformatf("n=%0d divisor_sum=%0d expected %0d",
                                    item.number, out_ch.divisor_sum, item.sum));
      end
    end
  end

  task automatic test_directed();
    logic [NUMBER_IN_W-1:0] numbers[$];
    numbers = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd16, 16'd25,
                16'd6, 16'd28, 16'd496, 16'd8128, 16'd220, 16'd284, 16'd12,
                16'd65535, 16'd65534, 16'd65521, 16'd65025, 16'd64516,
                16'd32768, 16'h5555, 16'haaaa, 16'd1024};
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    foreach (numbers[k]) send_number(numbers[k]);
  endtask

  task automatic test_random_small();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (35) send_number(NUMBER_IN_W'($urandom_range(0, 1023)));
  endtask

  task automatic test_random_mixed();
    int pick;
    logic [NUMBER_IN_W-1:0] number;
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (45) begin
      pick = $urandom_range(0, 9);
      // mostly small numbers keep the run short, a few span all 16 bits
      if (pick < 6) number = NUMBER_IN_W'($urandom_range(0, 4095));
      else if (pick < 8) number = NUMBER_IN_W'($urandom_range(0, 16383));
      else number = NUMBER_IN_W'($urandom_range(0, 65535));
      send_number(number);
    end
  endtask

  task automatic test_back_to_back();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    repeat (15) send_number(NUMBER_IN_W'($urandom_range(0, 255)));
    recv_idle_on = 1'b1;
    repeat (5) send_number(NUMBER_IN_W'($urandom_range(0, 255)));
  endtask

  task automatic test_drain_pause();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (8) send_number(NUMBER_IN_W'($urandom_range(0, 2047)));
    release_input();
    wait (pending_sums.size() == 0);
    repeat (8) send_number(NUMBER_IN_W'($urandom_range(0, 2047)));
  endtask

  initial begin
    error_count     = 0;
    send_idle_on    = 1'b1;
    recv_idle_on    = 1'b1;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.number_in = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_small();
    test_back_to_back();
    test_random_mixed();
    test_drain_pause();
    release_input();

    wait (pending_sums.size() == 0);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("proper_divisor_sum_unit test passed");
    end else begin
      $display("proper_divisor_sum_unit test failed");
    end
    $finish;
  end

endmodule
